[src/nptss_pkg.sv]
`default_nettype none
package nptss_pkg;

	localparam int COORD_BITS = 24;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * DIFF_BITS;
	localparam int DIST_BITS  = SQ_BITS + 2;
	localparam int MAXD_BITS  = 24;
	localparam int IDX_BITS   = 10;
	localparam int MODE_BITS  = 3;
	localparam int STAT_BITS  = 2;

	localparam logic [MODE_BITS-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_SET    = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_DEACT  = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_QUERY  = 3'd4;

	localparam logic [STAT_BITS-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_REFUSED = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_NONE    = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} pos_t;

	// table write strobes
	typedef struct packed {
		logic pos_en;
		logic live_en;
		logic live_bit;
	} wr_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

endpackage
`default_nettype wire

[src/nptss_table.sv]
`default_nettype none
module nptss_table #(
	parameter int DEPTH = 1024,
	parameter int IW    = 10
) (
	input  wire logic                clk,
	input  wire logic [IW-1:0]       wr_addr,
	input  wire nptss_pkg::wr_ctl_t  wr_ctl,
	input  wire nptss_pkg::pos_t     wr_pos,
	input  wire logic                rd_en,
	input  wire logic [IW-1:0]       rd_addr,
	output nptss_pkg::pos_t          rd_pos,
	output logic                     rd_live
);

	nptss_pkg::pos_t pos_mem [DEPTH];
	logic            live_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_ctl.pos_en) begin
			pos_mem[wr_addr] <= wr_pos;
		end
		if (wr_ctl.live_en) begin
			live_mem[wr_addr] <= wr_ctl.live_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pos  <= pos_mem[rd_addr];
			rd_live <= live_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[src/nptss_dist.sv]
`default_nettype none
module nptss_dist #(
	parameter int IW = 10
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_vld,
	input  wire logic [IW-1:0]                      in_idx,
	input  wire logic                               in_live,
	input  wire nptss_pkg::pos_t                    pt,
	input  wire nptss_pkg::pos_t                    qry,
	output logic                                    out_vld,
	output logic [IW-1:0]                           out_idx,
	output logic [nptss_pkg::DIST_BITS-1:0]         out_dist,
	output logic                                    busy
);

	localparam int DB = nptss_pkg::DIFF_BITS;
	localparam int CB = nptss_pkg::COORD_BITS;

	logic signed [DB-1:0] dx, dy, dz;
	logic [DB-1:0] ax, ay, az;
	logic [nptss_pkg::SQ_BITS-1:0] sqx, sqy, sqz;

	logic                vld_s1, vld_s2, vld_s3;
	logic [IW-1:0]       idx_s1, idx_s2, idx_s3;
	logic [DB-1:0]       ax_s1, ay_s1, az_s1;
	logic [nptss_pkg::SQ_BITS-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [nptss_pkg::DIST_BITS-1:0] dist_s3;

	always_comb begin
		dx = {pt.x[CB-1], pt.x} - {qry.x[CB-1], qry.x};
		dy = {pt.y[CB-1], pt.y} - {qry.y[CB-1], qry.y};
		dz = {pt.z[CB-1], pt.z} - {qry.z[CB-1], qry.z};
		ax = dx[DB-1] ? DB'(-dx) : DB'(dx);
		ay = dy[DB-1] ? DB'(-dy) : DB'(dy);
		az = dz[DB-1] ? DB'(-dz) : DB'(dz);
		sqx = ax_s1 * ax_s1;
		sqy = ay_s1 * ay_s1;
		sqz = az_s1 * az_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			// dead entries drop out here
			vld_s1 <= in_vld && in_live;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= in_idx;
		ax_s1   <= ax;
		ay_s1   <= ay;
		az_s1   <= az;
		idx_s2  <= idx_s1;
		sqx_s2  <= sqx;
		sqy_s2  <= sqy;
		sqz_s2  <= sqz;
		idx_s3  <= idx_s2;
		dist_s3 <= nptss_pkg::DIST_BITS'(sqx_s2) + nptss_pkg::DIST_BITS'(sqy_s2)
			+ nptss_pkg::DIST_BITS'(sqz_s2);
	end

	assign out_vld  = vld_s3;
	assign out_idx  = idx_s3;
	assign out_dist = dist_s3;
	assign busy     = vld_s1 || vld_s2 || vld_s3;

endmodule
`default_nettype wire

[src/nearest_point_table_search_top.sv]
`default_nettype none
// Nearest point table search over a table of TABLE_DEPTH 3D points.
// Input channel s_*: one command per transfer. s_tuser carries the mode
// (append, set position, deactivate, clear, nearest query); s_tdata carries
// entry index, x, y, z and the search limit max_distance.
// Output channel m_*: exactly one result per command, in command order.
// m_tuser carries the status (done, refused, no point found), m_tdata the
// index of the appended or nearest point, else zero.
// Flow: append, set position, deactivate, clear and unknown modes pass
// through the result state into the output register, and s_tready returns in
// the same cycle that m_tvalid rises. A query reads one table entry per
// cycle through the single read port of the point memory, then drains a
// three-stage distance pipeline before it enters the result state.
// One command is in work at a time. A finished result waits in the output
// register while the block takes the next command; if m_tready stays low,
// that next command's result holds inside the block and s_tready stays low.
// Reset empties the table (fill count zero) and drops any pending result;
// the point memory itself is not cleared, since only filled entries are read.
module nearest_point_table_search_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [9:0] entry_index, [33:10] coord_x, [57:34] coord_y, [81:58] coord_z,
	// [105:82] max_distance, [111:106] zero
	input  wire logic [111:0] s_tdata,
	// [2:0] mode
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [9:0] result_index, [15:10] zero
	output logic [15:0]       m_tdata,
	// [1:0] status
	output logic [1:0]        m_tuser
);

	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > nptss_pkg::IDX_BITS) ? CW : nptss_pkg::IDX_BITS;
	localparam int DW   = nptss_pkg::DIST_BITS;

	nptss_pkg::state_t state_q;
	logic [CW-1:0]     used_q, scan_ptr_q;
	nptss_pkg::pos_t   qry_q;
	logic [DW-1:0]     best_q;
	logic [IW-1:0]     best_idx_q;
	logic              found_q;
	logic              rd_vld_q;
	logic [IW-1:0]     rd_idx_q;
	logic [1:0]        res_status_q;
	logic [nptss_pkg::IDX_BITS-1:0] res_idx_q;
	logic              m_tvalid_q;
	logic [1:0]        m_status_q;
	logic [nptss_pkg::IDX_BITS-1:0] m_idx_q;

	logic [2:0]                       mode_in;
	logic [nptss_pkg::IDX_BITS-1:0]   idx_in;
	logic [nptss_pkg::MAXD_BITS-1:0]  maxd_in;
	logic [2*nptss_pkg::MAXD_BITS-1:0] maxd_sq;
	nptss_pkg::pos_t                  pos_in;
	logic [CMPW-1:0]                  idx_ext, used_ext, best_ext;
	logic                             accept, full, idx_ok, out_free;
	logic [IW-1:0]                    wr_addr;
	nptss_pkg::wr_ctl_t               wr_ctl;
	logic [1:0]                       acc_status;
	logic [nptss_pkg::IDX_BITS-1:0]   acc_idx;
	logic                             rd_en;
	logic [IW-1:0]                    rd_addr;
	nptss_pkg::pos_t                  rd_pos;
	logic                             rd_live;
	logic                             dist_vld, dist_busy, better;
	logic [IW-1:0]                    dist_idx;
	logic [DW-1:0]                    dist_sq;

	assign mode_in  = s_tuser[2:0];
	assign idx_in   = s_tdata[9:0];
	assign pos_in.x = s_tdata[33:10];
	assign pos_in.y = s_tdata[57:34];
	assign pos_in.z = s_tdata[81:58];
	assign maxd_in  = s_tdata[105:82];
	assign maxd_sq  = maxd_in * maxd_in;

	assign s_tready = (state_q == nptss_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign idx_ext  = CMPW'(idx_in);
	assign used_ext = CMPW'(used_q);
	assign best_ext = CMPW'(best_idx_q);
	assign full     = (used_q == CW'(TABLE_DEPTH));
	assign idx_ok   = (idx_ext < used_ext);
	assign out_free = !m_tvalid_q || m_tready;

	// table writes happen only at command accept, reads only while scanning,
	// so the FSM keeps the two ports from ever meeting on one entry
	always_comb begin
		wr_ctl     = '0;
		wr_addr    = idx_ext[IW-1:0];
		acc_status = nptss_pkg::ST_REFUSED;
		acc_idx    = '0;
		case (mode_in)
			nptss_pkg::MODE_APPEND: begin
				if (!full) begin
					wr_ctl.pos_en   = accept;
					wr_ctl.live_en  = accept;
					wr_ctl.live_bit = 1'b1;
					wr_addr         = used_q[IW-1:0];
					acc_status      = nptss_pkg::ST_DONE;
					acc_idx         = used_ext[nptss_pkg::IDX_BITS-1:0];
				end
			end
			nptss_pkg::MODE_SET: begin
				if (idx_ok) begin
					wr_ctl.pos_en = accept;
					acc_status    = nptss_pkg::ST_DONE;
				end
			end
			nptss_pkg::MODE_DEACT: begin
				if (idx_ok) begin
					wr_ctl.live_en = accept;
					acc_status     = nptss_pkg::ST_DONE;
				end
			end
			nptss_pkg::MODE_CLEAR: begin
				acc_status = nptss_pkg::ST_DONE;
			end
			default: begin
			end
		endcase
	end

	assign rd_en   = (state_q == nptss_pkg::S_SCAN) && (scan_ptr_q < used_q);
	assign rd_addr = scan_ptr_q[IW-1:0];
	assign better  = dist_vld && (dist_sq < best_q);

	nptss_table #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.wr_addr (wr_addr),
		.wr_ctl  (wr_ctl),
		.wr_pos  (pos_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_pos  (rd_pos),
		.rd_live (rd_live)
	);

	nptss_dist #(
		.IW (IW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (rd_vld_q),
		.in_idx   (rd_idx_q),
		.in_live  (rd_live),
		.pt       (rd_pos),
		.qry      (qry_q),
		.out_vld  (dist_vld),
		.out_idx  (dist_idx),
		.out_dist (dist_sq),
		.busy     (dist_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nptss_pkg::S_IDLE;
			used_q     <= '0;
			scan_ptr_q <= '0;
			found_q    <= 1'b0;
			rd_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			case (state_q)
				nptss_pkg::S_IDLE: begin
					if (accept) begin
						if (mode_in == nptss_pkg::MODE_QUERY) begin
							scan_ptr_q <= '0;
							found_q    <= 1'b0;
							state_q    <= nptss_pkg::S_SCAN;
						end else begin
							state_q <= nptss_pkg::S_RESULT;
						end
						if (mode_in == nptss_pkg::MODE_APPEND && !full) begin
							used_q <= used_q + 1'b1;
						end
						if (mode_in == nptss_pkg::MODE_CLEAR) begin
							used_q <= '0;
						end
					end
				end
				nptss_pkg::S_SCAN: begin
					if (rd_en) begin
						scan_ptr_q <= scan_ptr_q + 1'b1;
					end else begin
						state_q <= nptss_pkg::S_DRAIN;
					end
					if (better) begin
						found_q <= 1'b1;
					end
				end
				nptss_pkg::S_DRAIN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (!rd_vld_q && !dist_busy) begin
						state_q <= nptss_pkg::S_RESULT;
					end
				end
				nptss_pkg::S_RESULT: begin
					if (out_free) begin
						state_q <= nptss_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= nptss_pkg::S_IDLE;
				end
			endcase
			if (state_q == nptss_pkg::S_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= rd_addr;
		if (accept) begin
			qry_q        <= pos_in;
			best_q       <= DW'(maxd_sq);
			best_idx_q   <= '0;
			res_status_q <= acc_status;
			res_idx_q    <= acc_idx;
		end else if (better) begin
			// strict compare keeps the lowest index on ties
			best_q     <= dist_sq;
			best_idx_q <= dist_idx;
		end
		if (state_q == nptss_pkg::S_DRAIN) begin
			res_status_q <= found_q ? nptss_pkg::ST_DONE : nptss_pkg::ST_NONE;
			res_idx_q    <= found_q ? best_ext[nptss_pkg::IDX_BITS-1:0] : '0;
		end
		if (state_q == nptss_pkg::S_RESULT && out_free) begin
			m_status_q <= res_status_q;
			m_idx_q    <= res_idx_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {6'b0, m_idx_q};

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (scan_ptr_q < used_q) && !wr_ctl.pos_en && !wr_ctl.live_en)
		else $error("scan read outside filled entries or during a write");

	a_dist_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		dist_vld |-> (state_q == nptss_pkg::S_SCAN || state_q == nptss_pkg::S_DRAIN))
		else $error("distance result outside a query");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nptss_pkg::S_RESULT && out_free) |=>
		(m_tvalid && state_q == nptss_pkg::S_IDLE))
		else $error("pending result not moved to output");

	a_found_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nptss_pkg::S_DRAIN && found_q) |-> (best_q < DW'(maxd_sq)) ||
		$past(accept) == 1'b0)
		else $error("nearest point not below search limit");
`endif

endmodule
`default_nettype wire
